[rtl/chacha_pkg.sv]
// Shared types and constants for the ChaCha20 stream cipher block.
`default_nettype none
package chacha_pkg;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_NONCE_LOW = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
    localparam logic [2:0] REG_START_COUNTER = 3'd6;

    typedef logic [15:0][31:0] chacha_state_t;

    typedef struct packed {
        logic [63:0] data_in;
        logic [3:0]  byte_count;
        logic        is_last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] data_out;
        logic        out_last;
    } out_item_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    function automatic chacha_state_t quarter(input chacha_state_t x, input int a,
                                              input int b, input int c, input int d);
        chacha_state_t y;
        y = x;
        y[a] = y[a] + y[b]; y[d] = rotl(y[d] ^ y[a], 16);
        y[c] = y[c] + y[d]; y[b] = rotl(y[b] ^ y[c], 12);
        y[a] = y[a] + y[b]; y[d] = rotl(y[d] ^ y[a], 8);
        y[c] = y[c] + y[d]; y[b] = rotl(y[b] ^ y[c], 7);
        quarter = y;
    endfunction

    function automatic chacha_state_t double_round(input chacha_state_t x);
        chacha_state_t y;
        y = quarter(x, 0, 4, 8, 12);
        y = quarter(y, 1, 5, 9, 13);
        y = quarter(y, 2, 6, 10, 14);
        y = quarter(y, 3, 7, 11, 15);
        y = quarter(y, 0, 5, 10, 15);
        y = quarter(y, 1, 6, 11, 12);
        y = quarter(y, 2, 7, 8, 13);
        y = quarter(y, 3, 4, 9, 14);
        double_round = y;
    endfunction

endpackage
`default_nettype wire

[rtl/chacha_cell.sv]
// One double-round cell of the keystream chain.
`default_nettype none
module chacha_cell
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     valid,
    input  wire chacha_pkg::chacha_state_t work,
    input  wire chacha_pkg::chacha_state_t init,
    output logic                          valid_q,
    output chacha_pkg::chacha_state_t      work_q,
    output chacha_pkg::chacha_state_t      init_q
);

    logic                     valid_reg;
    chacha_pkg::chacha_state_t work_reg;
    chacha_pkg::chacha_state_t init_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid)
        begin
            work_reg <= chacha_pkg::double_round(work);
            init_reg <= init;
        end
    end

    assign valid_q = valid_reg;
    assign work_q  = work_reg;
    assign init_q  = init_reg;

endmodule
`default_nettype wire

[rtl/chacha20_stream_cipher_top.sv]
// Top level of the ChaCha20 stream cipher: message words in, XORed words out.
// A message word at block position zero launches a keystream block down a chain of
// DOUBLE_ROUNDS cells, one double round each, followed by a feed-forward stage into the
// keystream registers. The word that launches the block waits until the keystream
// registers hold the finished block and is then accepted; the other seven words of
// the block pass at one per cycle while the output is not stalled. A block is
// computed only once its first word arrives, so no next block is prepared while the
// words of the current one pass, and each block's first word waits on the cell chain.
`default_nettype none
module chacha20_stream_cipher_top
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire chacha_pkg::in_item_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output chacha_pkg::out_item_t      out_data,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [63:0]          cfg_wdata
);

    logic [63:0] key_reg [4];
    logic [63:0] nonce_low_reg;
    logic [31:0] nonce_high_reg;
    logic [31:0] start_counter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0; key_reg[1] <= '0; key_reg[2] <= '0; key_reg[3] <= '0;
            nonce_low_reg <= '0;
            nonce_high_reg <= '0;
            start_counter_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                chacha_pkg::REG_KEY0:          key_reg[0] <= cfg_wdata;
                chacha_pkg::REG_KEY1:          key_reg[1] <= cfg_wdata;
                chacha_pkg::REG_KEY2:          key_reg[2] <= cfg_wdata;
                chacha_pkg::REG_KEY3:          key_reg[3] <= cfg_wdata;
                chacha_pkg::REG_NONCE_LOW:     nonce_low_reg <= cfg_wdata;
                chacha_pkg::REG_NONCE_HIGH:    nonce_high_reg <= cfg_wdata[31:0];
                chacha_pkg::REG_START_COUNTER: start_counter_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Message position and counter.
    logic [2:0]  pos_reg;
    logic [31:0] block_count_reg;
    logic        in_message_reg;
    logic        ks_busy_reg;
    logic        ks_ready_reg;
    logic [63:0] ks_reg [8];

    logic        out_valid_reg;
    chacha_pkg::out_item_t out_reg;

    logic [31:0] ctr;
    logic        need_block;
    logic        can_out;
    logic        accept;

    assign ctr        = in_message_reg ? block_count_reg : start_counter_reg;
    assign need_block = !in_message_reg || (pos_reg == 3'd0);
    assign can_out    = !out_valid_reg || out_ready;
    // A word that needs a fresh block launches it and then waits on the chain.
    assign in_ready   = can_out && !ks_busy_reg && (!need_block || ks_ready_reg);
    assign accept     = in_valid && in_ready;

    logic launch;
    assign launch = in_valid && can_out && need_block && !ks_busy_reg && !ks_ready_reg;

    chacha_pkg::chacha_state_t init_state;
    always_comb
    begin
        init_state[0] = chacha_pkg::SIGMA0;
        init_state[1] = chacha_pkg::SIGMA1;
        init_state[2] = chacha_pkg::SIGMA2;
        init_state[3] = chacha_pkg::SIGMA3;
        for (int i = 0; i < 4; i++)
        begin
            init_state[4 + 2 * i] = key_reg[i][31:0];
            init_state[5 + 2 * i] = key_reg[i][63:32];
        end
        init_state[12] = ctr;
        init_state[13] = nonce_low_reg[31:0];
        init_state[14] = nonce_low_reg[63:32];
        init_state[15] = nonce_high_reg;
    end

    logic                      chain_valid [DOUBLE_ROUNDS + 1];
    chacha_pkg::chacha_state_t chain_work  [DOUBLE_ROUNDS + 1];
    chacha_pkg::chacha_state_t chain_init  [DOUBLE_ROUNDS + 1];

    assign chain_valid[0] = launch;
    assign chain_work[0]  = init_state;
    assign chain_init[0]  = init_state;

    for (genvar g = 0; g < DOUBLE_ROUNDS; g++)
    begin : g_cell
        chacha_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .valid   (chain_valid[g]),
            .work    (chain_work[g]),
            .init    (chain_init[g]),
            .valid_q (chain_valid[g + 1]),
            .work_q  (chain_work[g + 1]),
            .init_q  (chain_init[g + 1])
        );
    end

    logic done;
    assign done = chain_valid[DOUBLE_ROUNDS];

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            for (int i = 0; i < 8; i++)
            begin
                ks_reg[i] <= {chain_work[DOUBLE_ROUNDS][2 * i + 1]
                                  + chain_init[DOUBLE_ROUNDS][2 * i + 1],
                              chain_work[DOUBLE_ROUNDS][2 * i]
                                  + chain_init[DOUBLE_ROUNDS][2 * i]};
            end
        end
    end

    logic [2:0]  pos_use;
    logic [63:0] mask;
    logic [63:0] result;
    assign pos_use = in_message_reg ? pos_reg : 3'd0;
    assign result  = in_data.data_in ^ ks_reg[pos_use];

    always_comb
    begin
        mask = '1;
        if (in_data.is_last && (in_data.byte_count < 4'd8))
        begin
            mask = (64'd1 << {in_data.byte_count[2:0], 3'b000}) - 64'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            block_count_reg <= '0;
            in_message_reg <= 1'b0;
            ks_busy_reg <= 1'b0;
            ks_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (launch)
            begin
                ks_busy_reg <= 1'b1;
                block_count_reg <= ctr + 32'd1;
                in_message_reg <= 1'b1;
                pos_reg <= 3'd0;
            end
            if (done)
            begin
                ks_busy_reg <= 1'b0;
                ks_ready_reg <= 1'b1;
            end
            if (accept)
            begin
                if (need_block)
                begin
                    ks_ready_reg <= 1'b0;
                end
                if (in_data.is_last)
                begin
                    in_message_reg <= 1'b0;
                    pos_reg <= 3'd0;
                end
                else
                begin
                    in_message_reg <= 1'b1;
                    pos_reg <= pos_use + 3'd1;
                end
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg.data_out <= result & mask;
            out_reg.out_last <= in_data.is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

[rtl/chacha_checker.sv]
// Port-level checker for the ChaCha20 stream cipher top level.
`default_nettype none
module chacha_checker
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire chacha_pkg::in_item_t in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire chacha_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");

    a_one_per_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) && !out_valid |=> !out_valid)
        else $error("result beat without an input beat");

    a_last_copy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_data.out_last == $past(in_data.is_last))
        else $error("last flag not carried");

endmodule

bind chacha20_stream_cipher_top chacha_checker u_chacha_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
